// ----- sv/opfr_pkg.sv -----
// ----------------------------------------------------------------------------
// opfr_pkg
// Shared types and constants of the page framebuffer refresher.
// ----------------------------------------------------------------------------
package opfr_pkg;

    // request codes as they arrive on the input queue
    typedef enum logic [1:0] {
        REQ_DRAW   = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_UPDATE = 2'd3
    } t_req_type;

    // operations handed from the front to the back
    typedef enum logic [2:0] {
        OP_DRAW   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_UPDATE = 3'd3,
        OP_REJECT = 3'd4
    } t_op;

    localparam int PAGE_W     = 4;  // at most 16 pages
    localparam int WORD_IDX_W = 7;  // at most 128 words in a page
    localparam int LANE_W     = 3;  // at most 8 bytes in a word

    // refresh command bytes
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [3:0] CMD_COUNT  = 4'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        t_req_type   req_type;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [7:0]  page_index;
        logic [7:0]  byte_value;
    } t_request;

    typedef struct packed {
        logic        is_data;
        logic [3:0]  byte_count;
        logic [63:0] payload;
        logic        last;
        logic        status;
    } t_result;

    typedef struct packed {
        t_op                   op;
        logic [PAGE_W-1:0]     page;
        logic [WORD_IDX_W-1:0] word;
        logic [LANE_W-1:0]     lane;
        logic [7:0]            data;  // pixel mask for draw, byte for load
    } t_cmd;

endpackage

// ----- sv/opfr_front.sv -----
// ----------------------------------------------------------------------------
// opfr_front
// Takes requests, checks coordinates and splits the column into word and lane.
// ----------------------------------------------------------------------------
module opfr_front #(
    parameter int WIDTH      = 128,
    parameter int PAGES      = 16,
    parameter int WORD_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  opfr_pkg::t_request i_request,
    input  logic              i_init_busy,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output opfr_pkg::t_cmd    o_cmd
);

    localparam int RECIP = (4096 + WORD_BYTES - 1) / WORD_BYTES;
    localparam logic [8:0] WIDTH_L = 9'(WIDTH);
    localparam logic [8:0] ROWS_L  = 9'(PAGES * 8);
    localparam logic [8:0] PAGES_L = 9'(PAGES);

    logic                r_stg_valid;
    opfr_pkg::t_request  r_req;
    logic                r_ok;
    logic [opfr_pkg::WORD_IDX_W-1:0] r_quot;

    logic        accept;
    logic        ok;
    logic [20:0] prod;
    logic [10:0] lane_full;

    assign full   = i_init_busy | (r_stg_valid & ~i_cmd_ready);
    assign accept = push & ~full;

    // column / WORD_BYTES through a reciprocal, exact for columns below WIDTH
    assign prod = 21'(i_request.column) * 21'(RECIP);

    always_comb begin
        unique case (i_request.req_type)
            opfr_pkg::REQ_DRAW:   ok = ({1'b0, i_request.column} < WIDTH_L) &&
                                       ({1'b0, i_request.row} < ROWS_L);
            opfr_pkg::REQ_LOAD:   ok = ({1'b0, i_request.column} < WIDTH_L) &&
                                       ({1'b0, i_request.page_index} < PAGES_L);
            opfr_pkg::REQ_CLEAR:  ok = 1'b1;
            opfr_pkg::REQ_UPDATE: ok = ({1'b0, i_request.page_index} < PAGES_L);
            default:              ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (accept) begin
            r_stg_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_stg_valid <= 1'b0;
        end
        if (accept) begin
            r_req  <= i_request;
            r_ok   <= ok;
            r_quot <= prod[12 +: opfr_pkg::WORD_IDX_W];
        end
    end

    assign lane_full = 11'(r_req.column) - 11'(r_quot) * 11'(WORD_BYTES);

    always_comb begin
        o_cmd.word = r_quot;
        o_cmd.lane = lane_full[opfr_pkg::LANE_W-1:0];
        o_cmd.page = r_req.page_index[opfr_pkg::PAGE_W-1:0];
        o_cmd.data = r_req.byte_value;
        unique case (r_req.req_type)
            opfr_pkg::REQ_DRAW: begin
                o_cmd.op   = opfr_pkg::OP_DRAW;
                o_cmd.page = r_req.row[6:3];
                o_cmd.data = 8'd1 << r_req.row[2:0];
            end
            opfr_pkg::REQ_LOAD:   o_cmd.op = opfr_pkg::OP_LOAD;
            opfr_pkg::REQ_CLEAR:  o_cmd.op = opfr_pkg::OP_CLEAR;
            opfr_pkg::REQ_UPDATE: begin
                // a page refresh always starts at the first word
                o_cmd.op   = opfr_pkg::OP_UPDATE;
                o_cmd.word = '0;
            end
            default:              o_cmd.op = opfr_pkg::OP_REJECT;
        endcase
        if (!r_ok) begin
            o_cmd.op = opfr_pkg::OP_REJECT;
        end
    end

    assign o_cmd_valid = r_stg_valid;

endmodule

// ----- sv/opfr_queue.sv -----
// ----------------------------------------------------------------------------
// opfr_queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module opfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  opfr_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_pop,
    output opfr_pkg::t_cmd o_cmd
);

    opfr_pkg::t_cmd r_entry [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;
    assign o_cmd   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- sv/opfr_back.sv -----
// ----------------------------------------------------------------------------
// opfr_back
// Owns the framebuffer memory, carries out operations and drives results.
// ----------------------------------------------------------------------------
module opfr_back #(
    parameter int WIDTH      = 128,
    parameter int PAGES      = 16,
    parameter int WORD_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  opfr_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_init_busy,
    output logic              empty,
    input  logic              pop,
    output opfr_pkg::t_result o_result
);

    localparam int WPP      = (WIDTH + WORD_BYTES - 1) / WORD_BYTES;
    localparam int NROWS    = PAGES * WPP;
    localparam int AW       = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int RW       = WORD_BYTES * 8;
    localparam int LAST_CNT = WIDTH - (WPP - 1) * WORD_BYTES;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DRAW_WR,
        S_CLEAR,
        S_RD,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [AW-1:0]                   r_addr;
    logic [opfr_pkg::WORD_IDX_W-1:0] r_word;
    logic [opfr_pkg::LANE_W-1:0]     r_lane;
    logic [7:0]                      r_data;
    logic                            r_out_valid;
    opfr_pkg::t_result               r_result;

    logic [RW-1:0] r_mem [NROWS];
    logic [RW-1:0] r_rdata;

    logic                  out_free;
    logic                  cmd_take;
    logic [AW-1:0]         head_addr;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_addr;
    logic [WORD_BYTES-1:0] mem_be;
    logic [RW-1:0]         mem_wdata;

    assign out_free    = ~r_out_valid | pop;
    assign cmd_take    = (r_state == S_IDLE) & i_cmd_valid & out_free;
    assign head_addr   = AW'(int'(i_cmd.page) * WPP + int'(i_cmd.word));
    assign o_cmd_pop   = cmd_take;
    assign o_init_busy = (r_state == S_INIT);
    assign empty       = ~r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = r_addr;
        mem_be    = '1;
        mem_wdata = '0;
        unique case (r_state)
            S_INIT, S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                mem_addr = head_addr;
                if (cmd_take && i_cmd.op == opfr_pkg::OP_DRAW) begin
                    mem_re = 1'b1;
                end
                if (cmd_take && i_cmd.op == opfr_pkg::OP_LOAD) begin
                    mem_we    = 1'b1;
                    mem_be    = WORD_BYTES'(1) << i_cmd.lane;
                    mem_wdata = {WORD_BYTES{i_cmd.data}};
                end
            end
            S_DRAW_WR: begin
                mem_we = out_free;
                mem_be = WORD_BYTES'(1) << r_lane;
                for (int b = 0; b < WORD_BYTES; b++) begin
                    mem_wdata[b*8 +: 8] = r_rdata[b*8 +: 8] | r_data;
                end
            end
            S_RD: begin
                mem_re = 1'b1;
            end
            S_EMIT: begin
                mem_re = 1'b0;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // framebuffer memory with byte lanes, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int b = 0; b < WORD_BYTES; b++) begin
                if (mem_be[b]) begin
                    r_mem[mem_addr][b*8 +: 8] <= mem_wdata[b*8 +: 8];
                end
            end
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(NROWS - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cmd_take) begin
                        r_addr <= head_addr;
                        r_lane <= i_cmd.lane;
                        r_data <= i_cmd.data;
                        r_word <= '0;
                        unique case (i_cmd.op)
                            opfr_pkg::OP_DRAW: begin
                                r_state <= S_DRAW_WR;
                            end
                            opfr_pkg::OP_LOAD, opfr_pkg::OP_REJECT: begin
                                r_out_valid <= 1'b1;
                                r_result    <= '{is_data: 1'b0, byte_count: 4'd0,
                                                 payload: 64'd0, last: 1'b1,
                                                 status: (i_cmd.op == opfr_pkg::OP_REJECT)
                                                         ? opfr_pkg::STATUS_BAD
                                                         : opfr_pkg::STATUS_OK};
                            end
                            opfr_pkg::OP_CLEAR: begin
                                r_addr  <= '0;
                                r_state <= S_CLEAR;
                            end
                            opfr_pkg::OP_UPDATE: begin
                                r_out_valid <= 1'b1;
                                r_result    <= '{is_data: 1'b0,
                                                 byte_count: opfr_pkg::CMD_COUNT,
                                                 payload: {40'd0,
                                                           opfr_pkg::CMD_PAGE |
                                                           {4'd0, i_cmd.page},
                                                           opfr_pkg::CMD_COL_LO,
                                                           opfr_pkg::CMD_COL_HI},
                                                 last: 1'b0,
                                                 status: opfr_pkg::STATUS_OK};
                                r_state     <= S_RD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DRAW_WR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_result    <= '{is_data: 1'b0, byte_count: 4'd0, payload: 64'd0,
                                         last: 1'b1, status: opfr_pkg::STATUS_OK};
                        r_state     <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    if (r_addr != AW'(NROWS - 1)) begin
                        r_addr <= r_addr + AW'(1);
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_result    <= '{is_data: 1'b0, byte_count: 4'd0, payload: 64'd0,
                                         last: 1'b1, status: opfr_pkg::STATUS_OK};
                        r_state     <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_result.is_data <= 1'b1;
                        r_result.payload <= 64'(r_rdata);
                        r_result.status  <= opfr_pkg::STATUS_OK;
                        if (r_word == opfr_pkg::WORD_IDX_W'(WPP - 1)) begin
                            r_result.byte_count <= 4'(LAST_CNT);
                            r_result.last       <= 1'b1;
                            r_state             <= S_IDLE;
                        end else begin
                            r_result.byte_count <= 4'(WORD_BYTES);
                            r_result.last       <= 1'b0;
                            r_word              <= r_word + opfr_pkg::WORD_IDX_W'(1);
                            r_addr              <= r_addr + AW'(1);
                            r_state             <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/oled_page_framebuffer_refresher_top.sv -----
// ----------------------------------------------------------------------------
// oled_page_framebuffer_refresher_top
// Page-organized monochrome framebuffer with a page refresh byte stream.
// ----------------------------------------------------------------------------
// The framebuffer holds PAGES pages of WIDTH bytes, stored as rows of
// WORD_BYTES bytes in one single-port memory, so one data word of a page
// refresh is one memory read. After reset the block sweeps the memory to
// zero, one row a cycle, over all PAGES*ceil(WIDTH/WORD_BYTES) rows (256
// with the defaults); full stays high during the sweep. Steps per request,
// in the back end and given a free result slot: load byte and rejected
// requests get their result as they are taken; draw pixel does a memory
// read, then a byte-lane write; clear is taken, then sweeps the memory;
// update page gives the command result, then a read and an emit per data
// word. The single memory port puts these steps in sequence. A front stage
// and a two-entry queue keep taking requests while the back end works, and
// the result register frees itself on the cycle it is popped.
// ----------------------------------------------------------------------------
module oled_page_framebuffer_refresher_top #(
    parameter int WIDTH      = 128,  // columns, 8 to 128
    parameter int PAGES      = 16,   // pages of 8 rows, 1 to 16
    parameter int WORD_BYTES = 8     // bytes in one data word, 1 to 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              push,
    output logic              full,
    input  opfr_pkg::t_request i_request,
    // result side
    output logic              empty,
    input  logic              pop,
    output opfr_pkg::t_result o_result
);

    // front to queue
    logic           front_valid;
    opfr_pkg::t_cmd front_cmd;
    logic           queue_ready;

    // queue to back
    logic           queue_valid;
    opfr_pkg::t_cmd queue_cmd;
    logic           back_pop;

    // memory clearing after reset blocks new requests
    logic           init_busy;

    // classify requests and check coordinates
    opfr_front #(
        .WIDTH      (WIDTH),
        .PAGES      (PAGES),
        .WORD_BYTES (WORD_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_request   (i_request),
        .i_init_busy (init_busy),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (queue_ready),
        .o_cmd       (front_cmd)
    );

    // short queue so front and back stall independently
    opfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd)
    );

    // memory owner and result generator
    opfr_back #(
        .WIDTH      (WIDTH),
        .PAGES      (PAGES),
        .WORD_BYTES (WORD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (back_pop),
        .o_init_busy (init_busy),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule
